>>> rtl/rfc_pkg.sv
package rfc_pkg;

    localparam int W = 32;
    localparam int F = 16;
    localparam logic signed [W-1:0] EPS = 32'sd33;
    localparam logic signed [W-1:0] SMAX = 32'sh7fffffff;
    localparam logic signed [W-1:0] SMIN = 32'sh80000000;

    typedef enum logic [1:0] {
        REG_RADIUS_SQ   = 2'd0,
        REG_AXIAL_START = 2'd1,
        REG_AXIAL_END   = 2'd2,
        REG_UNBOUNDED   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [30:0]          radius_sq;
        logic signed [W-1:0]  axial_start;
        logic signed [W-1:0]  axial_end;
        logic                 unbounded;
    } cfg_t;

    // Saturate a wide signed value to the word.
    function automatic logic signed [W-1:0] sat(input logic signed [W+33:0] v);
        logic signed [W-1:0] r;
        if (v > $signed({{34{1'b0}}, SMAX}))
            r = SMAX;
        else if (v < $signed({{34{1'b1}}, SMIN}))
            r = SMIN;
        else
            r = v[W-1:0];
        return r;
    endfunction

    // Fixed point product, rounded half away from zero, saturated.
    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic [W:0]     ma;
        logic [W:0]     mb;
        logic [2*W+1:0] p;
        logic [2*W+1:0] s;
        logic           neg;
        logic [W:0]     lim;
        logic [W:0]     m;
        ma  = a[W-1] ? (W+1)'(-$signed({a[W-1], a})) : {1'b0, a};
        mb  = b[W-1] ? (W+1)'(-$signed({b[W-1], b})) : {1'b0, b};
        p   = ma * mb;
        s   = (p + (2*W+2)'(1 << (F-1))) >> F;
        neg = a[W-1] ^ b[W-1];
        lim = neg ? (W+1)'(33'h100000000 >> 1) : (W+1)'(SMAX);
        m   = (s > (2*W+2)'(lim)) ? lim : s[W:0];
        return neg ? (W)'(-$signed({1'b0, m})) : m[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] addsat(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        return sat((W+34)'(a) + (W+34)'(b));
    endfunction

    function automatic logic signed [W-1:0] subsat(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        return sat((W+34)'(a) - (W+34)'(b));
    endfunction

endpackage

>>> rtl/rfc_div.sv
// Pipelined restoring divider: q = m * 2^F / d, one quotient bit per stage.
module rfc_div (
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          num_mag,
    input  logic [31:0]          den,
    output logic [48:0]          quo
);
    import rfc_pkg::*;
    localparam int NB = 48;

    logic [NB-1:0] n_reg   [NB+1];
    logic [32:0]   r_reg   [NB+1];
    logic [NB-1:0] q_reg   [NB+1];
    logic [31:0]   d_reg   [NB+1];

    assign n_reg[0] = {num_mag, 16'd0};
    assign r_reg[0] = '0;
    assign q_reg[0] = '0;
    assign d_reg[0] = den;

    for (genvar i = 0; i < NB; i++) begin : g_st
        logic [33:0] tr;
        logic [32:0] r_next;
        logic        qb;
        always_comb
        begin
            tr     = {r_reg[i], n_reg[i][NB-1-i]};
            qb     = tr >= {2'b0, d_reg[i]};
            r_next = qb ? 33'(tr - {2'b0, d_reg[i]}) : tr[32:0];
        end
        logic [NB-1:0] ns;
        logic [32:0]   rs;
        logic [NB-1:0] qs;
        logic [31:0]   ds;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ns <= n_reg[i];
                rs <= r_next;
                qs <= q_reg[i] | (NB'(qb) << (NB-1-i));
                ds <= d_reg[i];
            end
        end
        assign n_reg[i+1] = ns;
        assign r_reg[i+1] = rs;
        assign q_reg[i+1] = qs;
        assign d_reg[i+1] = ds;
    end

    assign quo = {1'b0, q_reg[NB]};
endmodule

>>> rtl/rfc_sqrt.sv
// Pipelined integer square root: floor(sqrt(v * 2^F)), one result bit per stage.
module rfc_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] v,
    output logic [31:0] root
);
    import rfc_pkg::*;
    localparam int NB = 24;

    logic [47:0] t_reg [NB+1];
    logic [23:0] r_reg [NB+1];

    assign t_reg[0] = {v, 16'd0};
    assign r_reg[0] = '0;

    for (genvar i = 0; i < NB; i++) begin : g_st
        logic [23:0] c;
        logic [47:0] cc;
        logic [47:0] ts;
        logic [23:0] rs;
        always_comb
        begin
            c  = r_reg[i] | (24'd1 << (NB-1-i));
            cc = c * c;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ts <= t_reg[i];
                rs <= (cc <= t_reg[i]) ? c : r_reg[i];
            end
        end
        assign t_reg[i+1] = ts;
        assign r_reg[i+1] = rs;
    end

    assign root = {8'd0, r_reg[NB]};
endmodule

>>> rtl/ray_finite_cylinder_intersect.sv
// Ray versus finite cylinder intersection, one test per transfer.
// Input channel s_axis_*: tdata carries origin_x..z, dir_x..z, center_x..z,
// axis_x..z, 32 bits each, origin_x in the lowest bits.
// Output channel m_axis_*: tdata carries hit (bit 0) and hit_distance
// (bits 31:1).
// Configuration channel cfg_*: index selects radius_sq, axial_start,
// axial_end or unbounded. cfg_ready is always high and a write takes effect
// at once, so writes belong where no transfer is in flight.
// The datapath is one pipeline whose stages all advance together. A new
// ray can be taken every cycle while the output is not stalled. The result
// is registered after these stages in order: five arithmetic stages, the
// 24-stage square root, the 48-stage dividers for the two roots running side
// by side, the hit point and axial projection stages, and the output
// register.
// When the receiver stalls, the whole pipeline holds, so nothing is lost
// or repeated; s_axis_tready then stays low until the output is taken.
// Reset clears all valid bits and loads the register defaults (radius 1.0,
// limits 0 to 1.0, bounded).
module ray_finite_cylinder_intersect (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,   // origin xyz, dir xyz, center xyz, axis xyz
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // hit, hit_distance
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import rfc_pkg::*;
    localparam int DL = 48;   // divider depth
    localparam int SL = 24;   // square root depth

    cfg_t cfg_reg;
    logic en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius_sq   <= 31'd65536;
            cfg_reg.axial_start <= '0;
            cfg_reg.axial_end   <= 32'sd65536;
            cfg_reg.unbounded   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RADIUS_SQ:   cfg_reg.radius_sq   <= cfg_data[30:0];
                REG_AXIAL_START: cfg_reg.axial_start <= cfg_data;
                REG_AXIAL_END:   cfg_reg.axial_end   <= cfg_data;
                REG_UNBOUNDED:   cfg_reg.unbounded   <= cfg_data[0];
                default:         cfg_reg.unbounded   <= cfg_reg.unbounded;
            endcase
        end
    end

    // Whole pipeline advances while the output slot is free or taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [31:0] ix [12];
    for (genvar k = 0; k < 12; k++) begin : g_in
        assign ix[k] = s_axis_tdata[32*k +: 32];
    end

    // Stage 1: P. Stage 2 below forms the dot products.
    logic signed [31:0] p1_reg [3], d1_reg [3], q1_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= subsat(ix[i], ix[6+i]);
                d1_reg[i] <= ix[3+i];
                q1_reg[i] <= ix[9+i];
            end
    end
    logic signed [31:0] qd2_reg, qp2_reg;
    logic signed [31:0] p2_reg [3], d2_reg [3], q2_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qd2_reg <= addsat(addsat(fmul(q1_reg[0], d1_reg[0]), fmul(q1_reg[1], d1_reg[1])),
                              fmul(q1_reg[2], d1_reg[2]));
            qp2_reg <= addsat(addsat(fmul(q1_reg[0], p1_reg[0]), fmul(q1_reg[1], p1_reg[1])),
                              fmul(q1_reg[2], p1_reg[2]));
            p2_reg <= p1_reg; d2_reg <= d1_reg; q2_reg <= q1_reg;
        end
    end
    // Stage 3: perpendicular components.
    logic signed [31:0] dp3_reg [3], pp3_reg [3], p3_reg [3], d3_reg [3], q3_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp3_reg[i] <= subsat(fmul(q2_reg[i], qd2_reg), d2_reg[i]);
                pp3_reg[i] <= subsat(fmul(q2_reg[i], qp2_reg), p2_reg[i]);
            end
            p3_reg <= p2_reg; d3_reg <= d2_reg; q3_reg <= q2_reg;
        end
    end
    // Stage 4: quadratic coefficients.
    logic signed [31:0] a4_reg, b4_reg, c4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg <= addsat(addsat(fmul(dp3_reg[0], dp3_reg[0]), fmul(dp3_reg[1], dp3_reg[1])),
                             fmul(dp3_reg[2], dp3_reg[2]));
            b4_reg <= addsat(
                addsat(addsat(fmul(dp3_reg[0], pp3_reg[0]), fmul(dp3_reg[1], pp3_reg[1])),
                       fmul(dp3_reg[2], pp3_reg[2])),
                addsat(addsat(fmul(dp3_reg[0], pp3_reg[0]), fmul(dp3_reg[1], pp3_reg[1])),
                       fmul(dp3_reg[2], pp3_reg[2])));
            c4_reg <= subsat(
                addsat(addsat(fmul(pp3_reg[0], pp3_reg[0]), fmul(pp3_reg[1], pp3_reg[1])),
                       fmul(pp3_reg[2], pp3_reg[2])),
                $signed({1'b0, cfg_reg.radius_sq}));
        end
    end
    // Stage 5: discriminant.
    logic signed [31:0] a5_reg, b5_reg, disc5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc5_reg <= subsat(fmul(b4_reg, b4_reg),
                                sat(34'sd4 * (W+34)'(fmul(a4_reg, c4_reg))));
            a5_reg <= a4_reg; b5_reg <= b4_reg;
        end
    end

    // Square root pipeline with the side data delayed alongside.
    logic [31:0] root;
    rfc_sqrt u_sqrt (.clk(clk), .en(en), .v(disc5_reg[31] ? 32'd0 : disc5_reg), .root(root));

    localparam int SW = 1 + 32 + 32 + 96 * 3;
    logic [SW-1:0] sd_reg [SL];
    logic [SW-1:0] sd_in;
    logic ok5;
    assign ok5 = (disc5_reg >= EPS) && (a5_reg > 0);
    // Geometry rides along from stage 3 copies, aligned by the shift registers geo_reg[0] and geo_reg[1].
    logic [287:0] geo_reg [2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= {p3_reg[0], p3_reg[1], p3_reg[2], d3_reg[0], d3_reg[1],
                           d3_reg[2], q3_reg[0], q3_reg[1], q3_reg[2]};
            geo_reg[1] <= geo_reg[0];
        end
    end
    assign sd_in = {ok5, a5_reg, b5_reg, geo_reg[1]};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= sd_in;
            for (int i = 1; i < SL; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // Numerators and denominator.
    logic ok6;
    logic signed [31:0] a6, b6, den, nn, nf;
    logic [287:0] geo6;
    assign {ok6, a6, b6, geo6} = sd_reg[SL-1];
    assign den = sat((W+34)'(a6) * 34'sd2);
    assign nn  = sat(-(W+34)'(b6) - (W+34)'(root));
    assign nf  = sat(-(W+34)'(b6) + (W+34)'(root));

    logic [48:0] qn, qf;
    rfc_div u_divn (.clk(clk), .en(en),
                    .num_mag(nn[31] ? 32'(-nn) : nn), .den(den), .quo(qn));
    rfc_div u_divf (.clk(clk), .en(en),
                    .num_mag(nf[31] ? 32'(-nf) : nf), .den(den), .quo(qf));

    logic [1+2+288-1:0] dd_reg [DL];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= {ok6, nn[31], nf[31], geo6};
            for (int i = 1; i < DL; i++)
                dd_reg[i] <= dd_reg[i-1];
        end
    end

    function automatic logic signed [31:0] qsat(input logic neg, input logic [48:0] m);
        logic [48:0] lim;
        lim = neg ? 49'h80000000 : 49'h7fffffff;
        if (m > lim)
            m = lim;
        return neg ? 32'(-$signed(m)) : m[31:0];
    endfunction

    logic ok7, nneg, fneg;
    logic [287:0] geo7;
    logic signed [31:0] tn, tf;
    assign {ok7, nneg, fneg, geo7} = dd_reg[DL-1];
    assign tn = qsat(nneg, qn);
    assign tf = qsat(fneg, qf);

    // Hit point stage: h = p + t d for both roots.
    logic signed [31:0] g [9];
    for (genvar k = 0; k < 9; k++) begin : g_geo
        assign g[k] = geo7[287-32*k -: 32];
    end
    logic signed [31:0] hn8_reg [3], hf8_reg [3], q8_reg [3], tn8_reg, tf8_reg;
    logic ok8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hn8_reg[i] <= addsat(g[i], fmul(tn, g[3+i]));
                hf8_reg[i] <= addsat(g[i], fmul(tf, g[3+i]));
                q8_reg[i]  <= g[6+i];
            end
            tn8_reg <= tn; tf8_reg <= tf;
            ok8_reg <= ok7 && (tn < tf) && (tn > EPS);
        end
    end
    // Axial projection stage.
    logic signed [31:0] axn9_reg, axf9_reg, tn9_reg, tf9_reg;
    logic ok9_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axn9_reg <= addsat(addsat(fmul(q8_reg[0], hn8_reg[0]), fmul(q8_reg[1], hn8_reg[1])),
                               fmul(q8_reg[2], hn8_reg[2]));
            axf9_reg <= addsat(addsat(fmul(q8_reg[0], hf8_reg[0]), fmul(q8_reg[1], hf8_reg[1])),
                               fmul(q8_reg[2], hf8_reg[2]));
            tn9_reg <= tn8_reg; tf9_reg <= tf8_reg; ok9_reg <= ok8_reg;
        end
    end
    // Select and output register.
    logic inn, inf, hit;
    logic signed [31:0] t;
    always_comb
    begin
        inn = cfg_reg.unbounded || (axn9_reg > cfg_reg.axial_start &&
                                    axn9_reg < cfg_reg.axial_end);
        inf = axf9_reg > cfg_reg.axial_start && axf9_reg < cfg_reg.axial_end;
        hit = ok9_reg && (inn || inf);
        t   = inn ? tn9_reg : tf9_reg;
    end

    // Valid bits travel in one shift line matching the data depth.
    localparam int VD = 5 + SL + DL + 2;
    logic [VD-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[VD-2:0], s_axis_tvalid};
            m_axis_tvalid <= v_reg[VD-1];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            m_axis_tdata <= hit ? {t[30:0], 1'b1} : 32'd0;
    end

    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    ap_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == 31'd0)
        else $error("miss carries distance");
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
endmodule
